// ----- src/ppem_pkg.sv -----
package ppem_pkg;

  typedef enum logic [2:0] {
    OP_QUEUE   = 3'd0,
    OP_DECODE  = 3'd1,
    OP_SERVICE = 3'd2,
    OP_LOOP    = 3'd3,
    OP_TREQ    = 3'd4,
    OP_THAND   = 3'd5,
    OP_RESET   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  localparam logic [2:0] CFG_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_INTERVAL = 3'd1;
  localparam logic [2:0] CFG_QLOW     = 3'd2;
  localparam logic [2:0] CFG_SDEC     = 3'd3;
  localparam logic [2:0] CFG_SLOOP    = 3'd4;

  localparam logic [4:0] MID_QEMPTY  = 5'd14;
  localparam logic [4:0] MID_TWAIT   = 5'd18;

  typedef struct packed {
    op_t         op;
    logic [31:0] elapsed_us;
    logic [31:0] queue_level;
    logic [15:0] produced_count;
    logic [31:0] iteration_count;
    logic        budget_hit;
    logic [31:0] time_ms;
  } evt_t;

endpackage

// ----- src/ppem_front.sv -----
module ppem_front #(
  parameter int QUEUE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             opcode,
  input  logic [31:0]            elapsed_us,
  input  logic [QUEUE_BITS-1:0]  queue_level,
  input  logic [15:0]            produced_count,
  input  logic [31:0]            iteration_count,
  input  logic                   budget_hit,
  input  logic [31:0]            time_ms,
  input  logic                   monitor_enable,
  output ppem_pkg::evt_t         q_data,
  output logic                   q_valid,
  input  logic                   q_pop
);
  import ppem_pkg::*;

  // two-entry event queue; disabled and unused events are dropped here
  evt_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, keep;
  evt_t       e;

  always_comb begin
    e.op              = op_t'(opcode);
    e.elapsed_us      = elapsed_us;
    e.queue_level     = 32'(queue_level);
    e.produced_count  = produced_count;
    e.iteration_count = iteration_count;
    e.budget_hit      = budget_hit;
    e.time_ms         = time_ms;
  end

  assign in_ready = (count != 2'd2);
  assign keep     = (e.op == OP_RESET) || (monitor_enable && e.op != OP_NONE);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= e;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_no_over: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !q_pop) |=> count == 2'd2)
    else $error("full queue lost entry");

endmodule

// ----- src/ppem_div.sv -----
module ppem_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  // restoring division, one quotient bit per cycle
  logic [63:0] q;
  logic [31:0] r;
  logic [31:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial    = {r, q[63]} - {1'b0, d};
  assign quotient = q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (divisor != 32'd0);
        done <= (divisor == 32'd0);
        q    <= (divisor == 32'd0) ? 64'd0 : dividend;
        r    <= 32'd0;
        d    <= divisor;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          r <= trial[31:0];
          q <= {q[62:0], 1'b1};
        end else begin
          r <= {r[30:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/ppem_back.sv -----
module ppem_back #(
  parameter int QUEUE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  ppem_pkg::evt_t  q_data,
  input  logic            q_valid,
  output logic            q_pop,
  input  logic            monitor_enable,
  input  logic [31:0]     interval_ms,
  input  logic [15:0]     queue_low_level,
  input  logic [31:0]     slow_decode_limit_us,
  input  logic [31:0]     slow_loop_limit_us,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [4:0]      metric_id,
  output logic [63:0]     metric_value,
  output logic            last_item
);
  import ppem_pkg::*;

  localparam logic [QUEUE_BITS-1:0] QMASK = '1;

  typedef enum logic [1:0] {S_RUN, S_PREP, S_DIV, S_EMIT} state_t;
  state_t state;

  logic [31:0] loop_count, loop_peak_us, slow_loop_count;
  logic [63:0] loop_sum_us;
  logic [31:0] service_count, service_peak_us, budget_hit_count;
  logic [63:0] service_sum_us, service_iter_sum;
  logic [31:0] decode_count, decode_peak_us, decode_slow_count, decode_zero_count;
  logic [63:0] decode_sum_us, decode_sample_sum;
  logic [QUEUE_BITS-1:0] queue_floor;
  logic [31:0] queue_low_count, queue_empty_count;
  logic        touch_waiting;
  logic [31:0] touch_start_ms, touch_count, touch_peak_ms;
  logic [63:0] touch_sum_ms;
  logic [31:0] next_report_time;

  logic [4:0]  mid;
  logic [63:0] val;
  logic        need_div, has_touch;
  logic [63:0] dsum;
  logic [31:0] dcnt;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [QUEUE_BITS-1:0] lvl_sat;
  logic [31:0] lat;
  logic        is_last;

  ppem_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dsum), .divisor(dcnt),
    .done(div_done), .quotient(div_q)
  );

  assign has_touch = (touch_count != 32'd0) || touch_waiting;
  assign is_last   = has_touch ? (mid == MID_TWAIT) : (mid == MID_QEMPTY);
  assign lvl_sat   = (q_data.queue_level > 32'(QMASK)) ? QMASK
                                                       : q_data.queue_level[QUEUE_BITS-1:0];
  assign lat       = q_data.time_ms - touch_start_ms;
  assign div_start = (state == S_PREP) && need_div;

  always_comb begin
    need_div = 1'b0;
    dsum     = 64'd0;
    dcnt     = 32'd0;
    val      = 64'd0;
    case (mid)
      5'd0:  begin need_div = 1'b1; dsum = loop_sum_us;      dcnt = loop_count;    end
      5'd1:  val = 64'(loop_peak_us);
      5'd2:  val = 64'(slow_loop_count);
      5'd3:  begin need_div = 1'b1; dsum = service_sum_us;   dcnt = service_count; end
      5'd4:  val = 64'(service_peak_us);
      5'd5:  begin need_div = 1'b1; dsum = service_iter_sum; dcnt = service_count; end
      5'd6:  val = 64'(budget_hit_count);
      5'd7:  begin need_div = 1'b1; dsum = decode_sum_us;    dcnt = decode_count;  end
      5'd8:  val = 64'(decode_peak_us);
      5'd9:  val = 64'(decode_slow_count);
      5'd10: val = decode_sample_sum;
      5'd11: val = 64'(decode_zero_count);
      5'd12: val = (queue_floor == QMASK) ? 64'd0 : 64'(queue_floor);
      5'd13: val = 64'(queue_low_count);
      5'd14: val = 64'(queue_empty_count);
      5'd15: val = 64'(touch_count);
      5'd16: begin need_div = 1'b1; dsum = touch_sum_ms; dcnt = touch_count; end
      5'd17: val = 64'(touch_peak_ms);
      5'd18: val = {63'd0, touch_waiting};
      default: val = 64'd0;
    endcase
  end

  assign q_pop = (state == S_RUN) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      out_valid <= 1'b0;
      mid <= 5'd0;
      loop_count <= '0; loop_sum_us <= '0; loop_peak_us <= '0; slow_loop_count <= '0;
      service_count <= '0; service_sum_us <= '0; service_iter_sum <= '0;
      service_peak_us <= '0; budget_hit_count <= '0;
      decode_count <= '0; decode_sum_us <= '0; decode_sample_sum <= '0;
      decode_peak_us <= '0; decode_slow_count <= '0; decode_zero_count <= '0;
      queue_floor <= QMASK; queue_low_count <= '0; queue_empty_count <= '0;
      touch_count <= '0; touch_sum_ms <= '0; touch_peak_ms <= '0;
      touch_waiting <= 1'b0; touch_start_ms <= '0; next_report_time <= '0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (q_valid) begin
            case (q_data.op)
              OP_QUEUE, OP_DECODE: begin
                if (lvl_sat < queue_floor) queue_floor <= lvl_sat;
                if (q_data.queue_level <= 32'(queue_low_level))
                  queue_low_count <= queue_low_count + 32'd1;
                if (q_data.queue_level == 32'd0)
                  queue_empty_count <= queue_empty_count + 32'd1;
                if (q_data.op == OP_DECODE) begin
                  decode_count <= decode_count + 32'd1;
                  decode_sum_us <= decode_sum_us + 64'(q_data.elapsed_us);
                  decode_sample_sum <= decode_sample_sum + 64'(q_data.produced_count);
                  if (q_data.elapsed_us > decode_peak_us) decode_peak_us <= q_data.elapsed_us;
                  if (q_data.elapsed_us >= slow_decode_limit_us)
                    decode_slow_count <= decode_slow_count + 32'd1;
                  if (q_data.produced_count == 16'd0)
                    decode_zero_count <= decode_zero_count + 32'd1;
                end
              end
              OP_SERVICE: begin
                service_count <= service_count + 32'd1;
                service_sum_us <= service_sum_us + 64'(q_data.elapsed_us);
                service_iter_sum <= service_iter_sum + 64'(q_data.iteration_count);
                if (q_data.elapsed_us > service_peak_us) service_peak_us <= q_data.elapsed_us;
                if (q_data.budget_hit) budget_hit_count <= budget_hit_count + 32'd1;
              end
              OP_LOOP: begin
                loop_count <= loop_count + 32'd1;
                loop_sum_us <= loop_sum_us + 64'(q_data.elapsed_us);
                if (q_data.elapsed_us > loop_peak_us) loop_peak_us <= q_data.elapsed_us;
                if (q_data.elapsed_us >= slow_loop_limit_us)
                  slow_loop_count <= slow_loop_count + 32'd1;
                if (next_report_time == 32'd0) begin
                  next_report_time <= q_data.time_ms + interval_ms;
                end else if (q_data.time_ms >= next_report_time) begin
                  next_report_time <= q_data.time_ms + interval_ms;
                  mid <= 5'd0;
                  state <= S_PREP;
                end
              end
              OP_TREQ: begin
                touch_waiting <= 1'b1;
                touch_start_ms <= q_data.time_ms;
              end
              OP_THAND: begin
                if (touch_waiting) begin
                  touch_waiting <= 1'b0;
                  touch_count <= touch_count + 32'd1;
                  touch_sum_ms <= touch_sum_ms + 64'(lat);
                  if (lat > touch_peak_ms) touch_peak_ms <= lat;
                end
              end
              OP_RESET: begin
                loop_count <= '0; loop_sum_us <= '0; loop_peak_us <= '0;
                slow_loop_count <= '0; service_count <= '0; service_sum_us <= '0;
                service_iter_sum <= '0; service_peak_us <= '0; budget_hit_count <= '0;
                decode_count <= '0; decode_sum_us <= '0; decode_sample_sum <= '0;
                decode_peak_us <= '0; decode_slow_count <= '0; decode_zero_count <= '0;
                queue_floor <= QMASK; queue_low_count <= '0; queue_empty_count <= '0;
                touch_count <= '0; touch_sum_ms <= '0; touch_peak_ms <= '0;
                touch_waiting <= 1'b0; touch_start_ms <= '0;
                next_report_time <= (monitor_enable && interval_ms != 32'd0)
                                    ? q_data.time_ms + interval_ms : 32'd0;
              end
              default: ;
            endcase
          end
        end
        S_PREP: begin
          if (need_div) begin
            state <= S_DIV;
          end else begin
            metric_id <= mid;
            metric_value <= val;
            last_item <= is_last;
            out_valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            metric_id <= mid;
            metric_value <= 64'(div_q);
            last_item <= is_last;
            out_valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_item) begin
              state <= S_RUN;
              loop_count <= '0; loop_sum_us <= '0; loop_peak_us <= '0;
              slow_loop_count <= '0; service_count <= '0; service_sum_us <= '0;
              service_iter_sum <= '0; service_peak_us <= '0; budget_hit_count <= '0;
              decode_count <= '0; decode_sum_us <= '0; decode_sample_sum <= '0;
              decode_peak_us <= '0; decode_slow_count <= '0; decode_zero_count <= '0;
              queue_floor <= QMASK; queue_low_count <= '0; queue_empty_count <= '0;
              touch_count <= '0; touch_sum_ms <= '0; touch_peak_ms <= '0;
            end else begin
              mid <= mid + 5'd1;
              state <= S_PREP;
            end
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  a_out_emit: assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_EMIT)
    else $error("output valid outside emit");
  a_pop_run: assert property (@(posedge clk) disable iff (rst) q_pop |-> !out_valid)
    else $error("event consumed during report");
  a_mid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> metric_id <= MID_TWAIT)
    else $error("metric id out of range");

endmodule

// ----- src/playback_perf_event_monitor.sv -----
// Performance event monitor. Each accepted beat is one event, counted in the back end;
// a two-entry queue lets events keep arriving while the back end is busy.
// A loop event that makes a report due holds the back end for the whole report:
// 15 or 19 metric beats, each average computed in the shared
// one-bit-per-cycle 64/32 divider (skipped, giving zero, when its count is zero),
// other metrics read directly, plus output waits.
module playback_perf_event_monitor #(
  parameter int QUEUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            opcode,
  input  logic [31:0]           elapsed_us,
  input  logic [QUEUE_BITS-1:0] queue_level,
  input  logic [15:0]           produced_count,
  input  logic [31:0]           iteration_count,
  input  logic                  budget_hit,
  input  logic [31:0]           time_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4:0]            metric_id,
  output logic [63:0]           metric_value,
  output logic                  last_item
);
  import ppem_pkg::*;

  logic        monitor_enable;
  logic [31:0] interval_ms, slow_decode_limit_us, slow_loop_limit_us;
  logic [15:0] queue_low_level;
  evt_t        q_data;
  logic        q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable <= 1'b1;
      interval_ms <= 32'd1000;
      queue_low_level <= 16'd0;
      slow_decode_limit_us <= '1;
      slow_loop_limit_us <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:   monitor_enable <= cfg_data[0];
        CFG_INTERVAL: interval_ms <= cfg_data;
        CFG_QLOW:     queue_low_level <= cfg_data[15:0];
        CFG_SDEC:     slow_decode_limit_us <= cfg_data;
        CFG_SLOOP:    slow_loop_limit_us <= cfg_data;
        default: ;
      endcase
    end
  end

  ppem_front #(.QUEUE_BITS(QUEUE_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .elapsed_us(elapsed_us), .queue_level(queue_level),
    .produced_count(produced_count), .iteration_count(iteration_count),
    .budget_hit(budget_hit), .time_ms(time_ms), .monitor_enable(monitor_enable),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  ppem_back #(.QUEUE_BITS(QUEUE_BITS)) u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .monitor_enable(monitor_enable), .interval_ms(interval_ms),
    .queue_low_level(queue_low_level), .slow_decode_limit_us(slow_decode_limit_us),
    .slow_loop_limit_us(slow_loop_limit_us), .out_valid(out_valid),
    .out_ready(out_ready), .metric_id(metric_id), .metric_value(metric_value),
    .last_item(last_item)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import ppem_pkg::*;

  typedef struct {
    logic [4:0]  id;
    logic [63:0] value;
    logic        last;
  } metric_t;

  class metric_board;
    metric_t pending[$];
    int errors;
    int checked;
    int reports;

    logic        en;
    logic [31:0] interval, sdec, sloop;
    logic [15:0] qlow;
    logic [31:0] loop_n, loop_pk, lp_slow;
    logic [63:0] loop_sum;
    logic [31:0] svc_n, svc_pk, hits;
    logic [63:0] svc_sum, svc_iter;
    logic [31:0] dec_n, dec_pk, dec_slow, dec_zero;
    logic [63:0] dec_sum, dec_samp;
    logic [15:0] qfloor;
    logic [31:0] qlow_n, qempty_n;
    logic        t_wait;
    logic [31:0] t_start, t_n, t_pk;
    logic [63:0] t_sum;
    logic [31:0] next_due;

    function void clear_window();
      loop_n = 0; loop_sum = 0; loop_pk = 0; lp_slow = 0;
      svc_n = 0; svc_sum = 0; svc_iter = 0; svc_pk = 0; hits = 0;
      dec_n = 0; dec_sum = 0; dec_samp = 0; dec_pk = 0; dec_slow = 0; dec_zero = 0;
      qfloor = 16'hffff; qlow_n = 0; qempty_n = 0;
      t_n = 0; t_sum = 0; t_pk = 0;
    endfunction

    function void init();
      en = 1; interval = 1000; qlow = 0; sdec = '1; sloop = '1;
      clear_window();
      t_wait = 0; t_start = 0; next_due = 0;
      errors = 0; checked = 0; reports = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_ENABLE: en = d[0];
        CFG_INTERVAL: interval = d;
        CFG_QLOW: qlow = d[15:0];
        CFG_SDEC: sdec = d;
        CFG_SLOOP: sloop = d;
        default: ;
      endcase
    endfunction

    function logic [63:0] avg(logic [63:0] s, logic [31:0] n);
      logic [63:0] q;
      if (n == 0) return 0;
      q = s / {32'd0, n};
      return {32'd0, q[31:0]};
    endfunction

    function void push(logic [4:0] id, logic [63:0] v);
      metric_t m;
      m.id = id; m.value = v; m.last = 0;
      pending.push_back(m);
    endfunction

    function void note_level(logic [15:0] lvl);
      if (lvl < qfloor) qfloor = lvl;
      if (lvl <= qlow) qlow_n++;
      if (lvl == 0) qempty_n++;
    endfunction

    function void emit_report(logic [31:0] now);
      push(0, avg(loop_sum, loop_n));
      push(1, 64'(loop_pk));
      push(2, 64'(lp_slow));
      push(3, avg(svc_sum, svc_n));
      push(4, 64'(svc_pk));
      push(5, avg(svc_iter, svc_n));
      push(6, 64'(hits));
      push(7, avg(dec_sum, dec_n));
      push(8, 64'(dec_pk));
      push(9, 64'(dec_slow));
      push(10, dec_samp);
      push(11, 64'(dec_zero));
      push(12, qfloor == 16'hffff ? 64'd0 : {48'd0, qfloor});
      push(13, 64'(qlow_n));
      push(MID_QEMPTY, 64'(qempty_n));
      if (t_n > 0 || t_wait) begin
        push(15, 64'(t_n));
        push(16, avg(t_sum, t_n));
        push(17, 64'(t_pk));
        push(MID_TWAIT, {63'd0, t_wait});
      end
      pending[$].last = 1;
      reports++;
      clear_window();
      next_due = now + interval;
    endfunction

    function void note_event(evt_t e);
      logic [31:0] lat;
      if (e.op == OP_RESET) begin
        clear_window();
        t_wait = 0; t_start = 0; next_due = 0;
        if (en && interval != 0) next_due = e.time_ms + interval;
        return;
      end
      if (!en) return;
      case (e.op)
        OP_QUEUE: note_level(e.queue_level[15:0]);
        OP_DECODE: begin
          note_level(e.queue_level[15:0]);
          dec_n++;
          dec_sum += 64'(e.elapsed_us);
          dec_samp += 64'(e.produced_count);
          if (e.elapsed_us > dec_pk) dec_pk = e.elapsed_us;
          if (e.elapsed_us >= sdec) dec_slow++;
          if (e.produced_count == 0) dec_zero++;
        end
        OP_SERVICE: begin
          svc_n++;
          svc_sum += 64'(e.elapsed_us);
          svc_iter += 64'(e.iteration_count);
          if (e.elapsed_us > svc_pk) svc_pk = e.elapsed_us;
          if (e.budget_hit) hits++;
        end
        OP_LOOP: begin
          loop_n++;
          loop_sum += 64'(e.elapsed_us);
          if (e.elapsed_us > loop_pk) loop_pk = e.elapsed_us;
          if (e.elapsed_us >= sloop) lp_slow++;
          if (next_due == 0) next_due = e.time_ms + interval;
          else if (e.time_ms >= next_due) emit_report(e.time_ms);
        end
        OP_TREQ: begin
          t_wait = 1;
          t_start = e.time_ms;
        end
        OP_THAND: if (t_wait) begin
          lat = e.time_ms - t_start;
          t_wait = 0;
          t_n++;
          t_sum += 64'(lat);
          if (lat > t_pk) t_pk = lat;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_metric(logic [4:0] id, logic [63:0] v, logic last);
      metric_t m;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat id", 64'(id), 0);
        return;
      end
      m = pending.pop_front();
      checked++;
      if (id !== m.id) report_mismatch("metric_id", 64'(id), 64'(m.id));
      if (v !== m.value) report_mismatch("metric_value", v, m.value);
      if (last !== m.last) report_mismatch("last_item", 64'(last), 64'(m.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] opcode = 0;
  logic [31:0] elapsed_us = 0;
  logic [15:0] queue_level = 0;
  logic [15:0] produced_count = 0;
  logic [31:0] iteration_count = 0;
  logic budget_hit = 0;
  logic [31:0] time_ms = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [4:0] metric_id;
  logic [63:0] metric_value;
  logic last_item;

  metric_board board;
  int cycles = 0;
  int hold_off = 0;
  bit hold_used = 0;
  bit rx_enable = 1;
  logic [31:0] clock_ms = 0;
  int sent = 0;

  playback_perf_event_monitor dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_metric(metric_id, metric_value, last_item);
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      hold_off <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else if (!rx_enable && !hold_used) begin
      hold_off <= 400;
      hold_used <= 1;
      out_ready <= 0;
    end else if (!rx_enable) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 99) < 70);
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task send(evt_t e);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= e.op;
    elapsed_us <= e.elapsed_us;
    queue_level <= e.queue_level[15:0];
    produced_count <= e.produced_count;
    iteration_count <= e.iteration_count;
    budget_hit <= e.budget_hit;
    time_ms <= e.time_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_event(e);
    sent++;
  endtask

  task write_reg(logic [2:0] idx, logic [31:0] d);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(idx, d);
  endtask

  task drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  function evt_t make_evt(op_t op, logic [31:0] el, logic [15:0] lvl, logic [15:0] prod,
                          logic [31:0] it, logic hit, logic [31:0] t);
    evt_t e;
    e.op = op; e.elapsed_us = el; e.queue_level = {16'd0, lvl};
    e.produced_count = prod; e.iteration_count = it; e.budget_hit = hit; e.time_ms = t;
    return e;
  endfunction

  function evt_t rand_evt(bit loop_heavy);
    evt_t e;
    int r;
    r = $urandom_range(0, 99);
    e.op = op_t'($urandom_range(0, 7));
    if (loop_heavy && r < 15) e.op = OP_LOOP;
    else if (r < 90 && e.op == OP_RESET) e.op = OP_QUEUE;
    e.elapsed_us = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
    e.queue_level = {16'd0, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 40))};
    e.produced_count = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
    e.iteration_count = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
    e.budget_hit = 1'($urandom_range(0, 1));
    clock_ms = clock_ms + (($urandom_range(0, 30) == 0) ? $urandom : $urandom_range(0, 60));
    e.time_ms = clock_ms;
    return e;
  endfunction

  task random_phase(int n);
    repeat (n) send(rand_evt(1));
    drain();
  endtask

  initial begin
    board = new();
    board.init();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(CFG_QLOW, 32'hffff);
    write_reg(CFG_SDEC, 0);
    write_reg(CFG_SLOOP, 0);
    write_reg(CFG_INTERVAL, 10);
    send(make_evt(OP_LOOP, 32'hffffffff, 0, 0, 0, 0, 5));
    send(make_evt(OP_QUEUE, 0, 16'hffff, 0, 0, 0, 0));
    send(make_evt(OP_QUEUE, 0, 0, 0, 0, 0, 0));
    send(make_evt(OP_DECODE, 32'hffffffff, 7, 0, 0, 0, 0));
    send(make_evt(OP_DECODE, 0, 16'hffff, 16'hffff, 0, 0, 0));
    send(make_evt(OP_SERVICE, 32'hffffffff, 0, 0, 32'hffffffff, 1, 0));
    send(make_evt(OP_SERVICE, 0, 0, 0, 0, 0, 0));
    send(make_evt(OP_THAND, 0, 0, 0, 0, 0, 9));
    send(make_evt(OP_TREQ, 0, 0, 0, 0, 0, 32'hfffffff0));
    send(make_evt(OP_THAND, 0, 0, 0, 0, 0, 32'h20));
    send(make_evt(OP_TREQ, 0, 0, 0, 0, 0, 20));
    send(make_evt(OP_NONE, 1, 1, 1, 1, 1, 1));
    send(make_evt(OP_LOOP, 3, 0, 0, 0, 0, 15));
    send(make_evt(OP_LOOP, 3, 0, 0, 0, 0, 16));
    send(make_evt(OP_LOOP, 0, 0, 0, 0, 0, 0));
    send(make_evt(OP_RESET, 0, 0, 0, 0, 0, 32'hffffffff));
    send(make_evt(OP_LOOP, 0, 0, 0, 0, 0, 32'hffffffff));
    drain();
    write_reg(CFG_ENABLE, 0);
    send(make_evt(OP_QUEUE, 0, 0, 0, 0, 0, 0));
    send(make_evt(OP_RESET, 0, 0, 0, 0, 0, 3));
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_INTERVAL, 0);
    send(make_evt(OP_RESET, 0, 0, 0, 0, 0, 3));
    send(make_evt(OP_LOOP, 0, 0, 0, 0, 0, 3));
    send(make_evt(OP_LOOP, 0, 0, 0, 0, 0, 3));
    drain();

    write_reg(CFG_INTERVAL, 40);
    write_reg(CFG_QLOW, 5);
    write_reg(CFG_SDEC, 2500);
    write_reg(CFG_SLOOP, 2500);
    random_phase(120);

    rx_enable = 0;
    write_reg(CFG_INTERVAL, 0);
    repeat (30) send(make_evt(OP_LOOP, $urandom, 0, 0, 0, 0, clock_ms));
    rx_enable = 1;
    drain();

    write_reg(CFG_INTERVAL, 32'hffffffff);
    write_reg(CFG_QLOW, 0);
    write_reg(CFG_SDEC, 32'hffffffff);
    write_reg(CFG_SLOOP, 32'hffffffff);
    random_phase(80);

    write_reg(CFG_INTERVAL, 100);
    write_reg(CFG_QLOW, 20);
    write_reg(CFG_SDEC, 100);
    write_reg(CFG_SLOOP, 100);
    write_reg(CFG_ENABLE, 0);
    random_phase(30);
    write_reg(CFG_ENABLE, 1);
    random_phase(190);

    $display("covered %0d events, %0d reports, %0d metric beats checked",
             sent, board.reports, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d beats missing", board.errors, board.pending.size());
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
